/* rtl/glwm_pkg.sv */
`timescale 1ns / 1ps
// shared types, character constants and helper functions for the glob wildcard matcher
// no dependencies; imported by every module of the block

package glwm_pkg;

    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_NAME    = 1'b1;

    typedef struct packed {
        logic       is_name;
        logic [7:0] code;
        logic       blank;
        logic       last;
    } glwm_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_DONE
    } glwm_state_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

/* rtl/glwm_front.sv */
`timescale 1ns / 1ps
// front stage: takes input transfers, folds case and flags blanks
// depends on glwm_pkg

module glwm_front import glwm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] char_code
    input  logic       s_axis_tuser,  // [0] req_type
    input  logic       s_axis_tlast,
    output logic       item_valid,
    input  logic       item_ready,
    output glwm_item_t item
);

    logic       valid_reg, valid_next;
    glwm_item_t item_reg, item_next;

    assign s_axis_tready = !valid_reg || item_ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (item_ready) begin
            valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next        = 1'b1;
            item_next.is_name = s_axis_tuser;
            item_next.code    = fold_case(s_axis_tdata);
            item_next.blank   = is_blank(s_axis_tdata);
            item_next.last    = s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

/* rtl/glwm_queue.sv */
`timescale 1ns / 1ps
// short queue of classified characters between the front and back stages
// depends on glwm_pkg

module glwm_queue import glwm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  glwm_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output glwm_item_t pop_item
);

    glwm_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/glwm_back.sv */
`timescale 1ns / 1ps
// back stage: pattern and name stores, trimmed lengths and the backtracking glob walk
// depends on glwm_pkg

module glwm_back import glwm_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_NAME    = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    output logic       item_ready,
    input  glwm_item_t item,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata   // [0] matched, [1] overflow, [7:2] zero
);

    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int NLEN_W = $clog2(MAX_NAME + 1);
    localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NIDX_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

    logic [7:0] pat_mem  [MAX_PATTERN];
    logic [7:0] name_mem [MAX_NAME];
    logic [7:0] pat_rd_reg, name_rd_reg;

    glwm_state_t state_reg, state_next;

    logic [PLEN_W-1:0] pat_len_reg, pat_len_next;
    logic [PLEN_W-1:0] pat_trim_reg, pat_trim_next;
    logic              pat_ovf_reg, pat_ovf_next;
    logic              pat_closed_reg, pat_closed_next;
    logic [NLEN_W-1:0] name_len_reg, name_len_next;
    logic [NLEN_W-1:0] name_trim_reg, name_trim_next;
    logic              name_ovf_reg, name_ovf_next;

    logic [PLEN_W-1:0] p_reg, p_next;
    logic [PLEN_W-1:0] star_reg, star_next;
    logic              have_star_reg, have_star_next;
    logic [NLEN_W-1:0] t_reg, t_next;
    logic [NLEN_W-1:0] resume_reg, resume_next;

    logic res_match_reg, res_match_next;
    logic res_ovf_reg, res_ovf_next;
    logic m_valid_reg, m_valid_next;
    logic [1:0] m_data_reg, m_data_next;

    logic              pat_we, name_we;
    logic [PIDX_W-1:0] pat_waddr;
    logic [NIDX_W-1:0] name_waddr;

    logic              take;
    logic              out_free;
    logic              match_start;
    logic              match_fail;
    logic              match_hit;
    logic              eval_done;
    logic [PLEN_W-1:0] pbase_len, pbase_trim;
    logic              pbase_ovf;
    logic              p_in, t_in;

    assign take      = (state_reg == ST_IDLE) && item_valid;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign item_ready = (state_reg == ST_IDLE);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_data_reg};

    assign pbase_len  = pat_closed_reg ? '0 : pat_len_reg;
    assign pbase_trim = pat_closed_reg ? '0 : pat_trim_reg;
    assign pbase_ovf  = pat_closed_reg ? 1'b0 : pat_ovf_reg;

    assign p_in = (p_reg < pat_trim_reg);
    assign t_in = (t_reg < name_trim_reg);

    // store updates
    always_comb begin
        pat_len_next    = pat_len_reg;
        pat_trim_next   = pat_trim_reg;
        pat_ovf_next    = pat_ovf_reg;
        pat_closed_next = pat_closed_reg;
        name_len_next   = name_len_reg;
        name_trim_next  = name_trim_reg;
        name_ovf_next   = name_ovf_reg;
        pat_we          = 1'b0;
        name_we         = 1'b0;
        pat_waddr       = pbase_len[PIDX_W-1:0];
        name_waddr      = name_len_reg[NIDX_W-1:0];
        match_start     = 1'b0;
        res_ovf_next    = res_ovf_reg;
        if (take) begin
            if (item.is_name == REQ_PATTERN) begin
                pat_len_next  = pbase_len;
                pat_trim_next = pbase_trim;
                pat_ovf_next  = pbase_ovf;
                if (!(pbase_len == '0 && item.blank)) begin
                    if (pbase_len < PLEN_W'(MAX_PATTERN)) begin
                        pat_we       = 1'b1;
                        pat_len_next = pbase_len + 1'b1;
                        if (!item.blank) begin
                            pat_trim_next = pbase_len + 1'b1;
                        end
                    end else begin
                        pat_ovf_next = 1'b1;
                    end
                end
                pat_closed_next = item.last;
            end else begin
                if (!(name_len_reg == '0 && item.blank)) begin
                    if (name_len_reg < NLEN_W'(MAX_NAME)) begin
                        name_we       = 1'b1;
                        name_len_next = name_len_reg + 1'b1;
                        if (!item.blank) begin
                            name_trim_next = name_len_reg + 1'b1;
                        end
                    end else begin
                        name_ovf_next = 1'b1;
                    end
                end
                if (item.last) begin
                    res_ovf_next = name_ovf_next || pat_ovf_reg;
                    match_start  = !res_ovf_next;
                end
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            name_len_next  = '0;
            name_trim_next = '0;
            name_ovf_next  = 1'b0;
        end
    end

    // glob walk decision, using the registered store reads
    always_comb begin
        match_fail = 1'b0;
        match_hit  = 1'b0;
        eval_done  = 1'b0;
        if (t_in) begin
            if (p_in && (pat_rd_reg == CH_QUESTION || pat_rd_reg == name_rd_reg)) begin
                match_fail = 1'b0;
            end else if (p_in && pat_rd_reg == CH_STAR) begin
                match_fail = 1'b0;
            end else if (!have_star_reg) begin
                match_fail = 1'b1;
                eval_done  = 1'b1;
            end
        end else if (!(p_in && pat_rd_reg == CH_STAR)) begin
            eval_done = 1'b1;
            match_hit = (p_reg == pat_trim_reg);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && item.is_name == REQ_NAME && item.last) begin
                    state_next = match_start ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH: state_next = ST_EVAL;
            ST_EVAL:  state_next = eval_done ? ST_DONE : ST_FETCH;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // walk registers and result outputs
    always_comb begin
        p_next         = p_reg;
        t_next         = t_reg;
        star_next      = star_reg;
        resume_next    = resume_reg;
        have_star_next = have_star_reg;
        res_match_next = res_match_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                p_next         = '0;
                t_next         = '0;
                star_next      = '0;
                resume_next    = '0;
                have_star_next = 1'b0;
                res_match_next = 1'b0;
            end
            ST_EVAL: begin
                if (eval_done) begin
                    res_match_next = match_hit && !match_fail;
                end else if (t_in) begin
                    if (p_in && (pat_rd_reg == CH_QUESTION || pat_rd_reg == name_rd_reg)) begin
                        p_next = p_reg + 1'b1;
                        t_next = t_reg + 1'b1;
                    end else if (p_in && pat_rd_reg == CH_STAR) begin
                        have_star_next = 1'b1;
                        star_next      = p_reg;
                        p_next         = p_reg + 1'b1;
                        resume_next    = t_reg;
                    end else begin
                        p_next      = star_reg + 1'b1;
                        resume_next = resume_reg + 1'b1;
                        t_next      = resume_reg + 1'b1;
                    end
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_ovf_reg, res_match_reg && !res_ovf_reg};
                end
            end
            default: begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pat_len_reg    <= '0;
            pat_trim_reg   <= '0;
            pat_ovf_reg    <= 1'b0;
            pat_closed_reg <= 1'b0;
            name_len_reg   <= '0;
            name_trim_reg  <= '0;
            name_ovf_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pat_len_reg    <= pat_len_next;
            pat_trim_reg   <= pat_trim_next;
            pat_ovf_reg    <= pat_ovf_next;
            pat_closed_reg <= pat_closed_next;
            name_len_reg   <= name_len_next;
            name_trim_reg  <= name_trim_next;
            name_ovf_reg   <= name_ovf_next;
            m_valid_reg    <= m_valid_next;
        end
        p_reg         <= p_next;
        t_reg         <= t_next;
        star_reg      <= star_next;
        resume_reg    <= resume_next;
        have_star_reg <= have_star_next;
        res_match_reg <= res_match_next;
        res_ovf_reg   <= res_ovf_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= item.code;
        end
        pat_rd_reg <= pat_mem[p_reg[PIDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (name_we) begin
            name_mem[name_waddr] <= item.code;
        end
        name_rd_reg <= name_mem[t_reg[NIDX_W-1:0]];
    end

endmodule

/* rtl/glob_wildcard_matcher.sv */
`timescale 1ns / 1ps
// glob wildcard matcher top level: front classifier, character queue and match engine
// depends on glwm_pkg, glwm_front, glwm_queue and glwm_back
//
// usage:
//   s_axis carries one character per transfer: tdata[7:0] is the raw byte,
//   tuser is 0 for a pattern character and 1 for a name character, tlast
//   closes the string. the pattern is kept across names; a pattern character
//   after a closed pattern starts a new one. both strings are trimmed of
//   space, tab, cr and lf at both ends and folded to lower case
//   m_axis gives one transfer per name closed with tlast:
//   tdata[0] matched, tdata[1] overflow (a store was too small, matched 0)
//   characters enter at one per cycle while the four-entry queue has room;
//   a character passes the front register and a queue slot to the stores.
//   the closing name character starts the walk; each step is a fetch
//   state that reads both stores, then an eval state; at most about
//   (pattern length + 1) * (name length + 1) steps, then the result is
//   registered; input back-pressures once the queue fills during the walk
//   reset clears lengths, flags, queue and output valid; the stores need none
//   a stalled m_axis holds the result and the engine waits before the next
//   load, so characters back up into the queue and then s_axis

module glob_wildcard_matcher import glwm_pkg::*; #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_NAME    = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tuser,   // [0] req_type
    input  logic       s_axis_tlast,   // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    logic       front_valid, front_ready;
    glwm_item_t front_item;
    logic       back_valid, back_ready;
    glwm_item_t back_item;

    glwm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    glwm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    glwm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_NAME    (MAX_NAME)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .item          (back_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
